// ----- hw/rtl/rsa_pkg.sv -----
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants for the rational sum accumulator.
// ----------------------------------------------------------------------------
package rsa_pkg;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_ZERO = 2'd1,
		ERR_OVF  = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		FORM_ZERO = 2'd0,
		FORM_FRAC = 2'd1,
		FORM_INT  = 2'd2,
		FORM_BOTH = 2'd3
	} form_t;

	// datapath commands
	typedef enum logic [3:0] {
		OP_NONE    = 4'd0,
		OP_LOAD    = 4'd1,  // capture request, start gcd(cd, den)
		OP_DIVCD   = 4'd2,  // div cd by g
		OP_DIVDEN  = 4'd3,  // div den by g
		OP_MUL1    = 4'd4,  // cdg*den
		OP_MUL2    = 4'd5,  // |sum|*dg
		OP_MUL3    = 4'd6,  // |num|*cdg
		OP_COMMIT  = 4'd7,  // add and update
		OP_FDIV    = 4'd8,  // |sum| / cd
		OP_FGCD    = 4'd9,  // gcd(|rem|, cd)
		OP_FDEN    = 4'd10, // cd / g
		OP_FREM    = 4'd11, // |rem| / g
		OP_CLEAR   = 4'd12  // load result, reset accumulator
	} op_t;

	typedef struct packed {
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic busy;     // divider, multiplier or gcd running
		logic err_held;
		logic last;
	} sts_t;

endpackage

// ----- hw/rtl/rational_sum_accumulator.sv -----
// ----------------------------------------------------------------------------
// rational_sum_accumulator
// Exact fraction accumulator with mixed-number result.
// ----------------------------------------------------------------------------
// One request at a time: after a fraction is accepted, s_axis_tready returns
// once the datapath has run the binary gcd of the common denominator and the
// new denominator, two divisions and three multiplications, with a handoff
// between stages. The fraction marked last adds a final gcd and three more
// divisions before the result is loaded into the output register and the
// accumulator clears. A result not yet taken stalls only the next last
// fraction, just before its own result is loaded. While a zero-denominator
// or overflow error is held, a request skips the arithmetic, and one marked
// last goes straight on to loading the result.
module rational_sum_accumulator import rsa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [63:0]   s_axis_tdata,   // numerator[31:0], denominator[62:32]
	input  logic          s_axis_tlast,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// integer_part[63:0], fraction_numerator[127:64], fraction_denominator[190:128],
	// form[192:191], error[194:193]
	output logic [199:0]  m_axis_tdata
);

	cmd_t        cmd;
	sts_t        sts;
	logic [63:0] r_int, r_rem;
	logic [62:0] r_den;
	logic [1:0]  r_form, r_err;
	logic        in_fire, out_fire;

	assign in_fire  = s_axis_tvalid & s_axis_tready;
	assign out_fire = m_axis_tvalid & m_axis_tready;

	rsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(s_axis_tlast),
		.in_den_zero(s_axis_tdata[62:32] == 31'd0), .out_fire(out_fire),
		.sts(sts), .cmd(cmd), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
	);

	rsa_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_num(s_axis_tdata[31:0]), .in_den(s_axis_tdata[62:32]),
		.in_last(s_axis_tlast), .res_int(r_int), .res_rem(r_rem), .res_den(r_den),
		.res_form(r_form), .res_err(r_err)
	);

	assign m_axis_tdata = {5'd0, r_err, r_form, r_den, r_rem, r_int};

endmodule

// ----- hw/rtl/rsa_datapath.sv -----
// ----------------------------------------------------------------------------
// rsa_datapath
// Shared 64-bit radix-2 divider, shift-add multiplier, binary gcd and
// accumulator.
// ----------------------------------------------------------------------------
module rsa_datapath import rsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [31:0]       in_num,
	input  logic [30:0]       in_den,
	input  logic              in_last,
	output logic [63:0]       res_int,
	output logic [63:0]       res_rem,
	output logic [62:0]       res_den,
	output logic [1:0]        res_form,
	output logic [1:0]        res_err
);

	logic [63:0] sum_q, cd_q;
	err_t        err_q;
	logic [31:0] num_q;
	logic [30:0] den_q;
	logic        last_q;

	logic [63:0] g_q, cdg_q, ncd_q, p1_q;
	logic [30:0] dg_q;
	logic        ovf_q;

	logic [63:0] quo_q, rem_q;
	logic [62:0] fden_q;
	logic        sneg_q;

	logic [63:0] res_int_q, res_rem_q;
	logic [62:0] res_den_q;
	form_t       res_form_q;
	err_t        res_err_q;

	// divider: q = dn / dd, one bit per cycle
	logic [63:0] dn_q, dd_q, dq_q, dr_q;
	logic [6:0]  dcnt_q;
	logic        dbusy_q;
	logic [64:0] dshift;
	logic [65:0] dtrial;

	// multiplier: 64x32 -> 96, one bit per cycle
	logic [63:0] ma_q;
	logic [95:0] mp_q;
	logic [5:0]  mcnt_q;
	logic        mbusy_q;
	logic [64:0] madd;

	// binary gcd
	logic [63:0] ga_q, gb_q;
	logic [5:0]  gk_q;
	logic        gbusy_q;

	logic [63:0] smag, s2;
	logic [31:0] nmag;
	logic [64:0] add_s;

	assign smag = sum_q[63] ? (64'd0 - sum_q) : sum_q;
	assign nmag = num_q[31] ? (32'd0 - num_q) : num_q;

	assign dshift = {dr_q, dn_q[63]};
	assign dtrial = {1'b0, dshift} - {2'b00, dd_q};

	assign madd = {1'b0, mp_q[95:32]} + (mp_q[0] ? {1'b0, ma_q} : 65'd0);

	assign s2    = num_q[31] ? (64'd0 - mp_q[63:0]) : mp_q[63:0];
	assign add_s = {p1_q[63], p1_q} + {s2[63], s2};

	// signed range check of |p| with sign
	function automatic logic rng_bad(input logic [95:0] p, input logic neg);
		if (p[95:64] != 32'd0) rng_bad = 1'b1;
		else if (neg) rng_bad = (p[63:0] > 64'h8000_0000_0000_0000);
		else rng_bad = p[63];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			cd_q       <= 64'd1;
			err_q      <= ERR_NONE;
			num_q      <= '0;
			den_q      <= '0;
			last_q     <= 1'b0;
			g_q        <= '0;
			cdg_q      <= '0;
			ncd_q      <= '0;
			p1_q       <= '0;
			dg_q       <= '0;
			ovf_q      <= 1'b0;
			quo_q      <= '0;
			rem_q      <= '0;
			fden_q     <= '0;
			sneg_q     <= 1'b0;
			res_int_q  <= '0;
			res_rem_q  <= '0;
			res_den_q  <= 63'd1;
			res_form_q <= FORM_ZERO;
			res_err_q  <= ERR_NONE;
			dn_q       <= '0;
			dd_q       <= '0;
			dq_q       <= '0;
			dr_q       <= '0;
			dcnt_q     <= '0;
			dbusy_q    <= 1'b0;
			ma_q       <= '0;
			mp_q       <= '0;
			mcnt_q     <= '0;
			mbusy_q    <= 1'b0;
			ga_q       <= '0;
			gb_q       <= '0;
			gk_q       <= '0;
			gbusy_q    <= 1'b0;
		end else begin
			if (dbusy_q) begin
				dr_q <= dtrial[65] ? dshift[63:0] : dtrial[63:0];
				dq_q <= {dq_q[62:0], ~dtrial[65]};
				dn_q <= {dn_q[62:0], 1'b0};
				dcnt_q <= dcnt_q - 7'd1;
				if (dcnt_q == 7'd1) dbusy_q <= 1'b0;
			end
			if (mbusy_q) begin
				mp_q <= {madd, mp_q[31:1]};
				mcnt_q <= mcnt_q - 6'd1;
				if (mcnt_q == 6'd1) mbusy_q <= 1'b0;
			end
			if (gbusy_q) begin
				if (ga_q == 64'd0) begin
					g_q <= gb_q << gk_q;
					gbusy_q <= 1'b0;
				end else if (gb_q == 64'd0) begin
					g_q <= ga_q << gk_q;
					gbusy_q <= 1'b0;
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= {1'b0, ga_q[63:1]};
					gb_q <= {1'b0, gb_q[63:1]};
					gk_q <= gk_q + 6'd1;
				end else if (!ga_q[0]) begin
					ga_q <= {1'b0, ga_q[63:1]};
				end else if (!gb_q[0]) begin
					gb_q <= {1'b0, gb_q[63:1]};
				end else if (ga_q >= gb_q) begin
					ga_q <= ga_q - gb_q;
				end else begin
					gb_q <= gb_q - ga_q;
				end
			end
			unique case (cmd.op)
				OP_LOAD: begin
					num_q  <= in_num;
					den_q  <= in_den;
					last_q <= in_last;
					if (err_q == ERR_NONE) begin
						if (in_den == 31'd0) begin
							err_q <= ERR_ZERO;
						end else begin
							ga_q <= cd_q; gb_q <= {33'd0, in_den};
							gk_q <= '0; gbusy_q <= 1'b1;
						end
					end
				end
				OP_DIVCD: begin
					dn_q <= cd_q; dd_q <= g_q; dr_q <= '0; dq_q <= '0;
					dcnt_q <= 7'd64; dbusy_q <= 1'b1;
				end
				OP_DIVDEN: begin
					cdg_q <= dq_q;
					dn_q <= {33'd0, den_q}; dd_q <= g_q; dr_q <= '0; dq_q <= '0;
					dcnt_q <= 7'd64; dbusy_q <= 1'b1;
				end
				OP_MUL1: begin
					dg_q <= dq_q[30:0];
					ma_q <= cdg_q; mp_q <= {64'd0, 1'b0, den_q};
					mcnt_q <= 6'd32; mbusy_q <= 1'b1;
				end
				OP_MUL2: begin
					ovf_q <= (mp_q[95:63] != 33'd0);
					ncd_q <= mp_q[63:0];
					ma_q <= smag; mp_q <= {64'd0, 1'b0, dg_q};
					mcnt_q <= 6'd32; mbusy_q <= 1'b1;
				end
				OP_MUL3: begin
					ovf_q <= ovf_q | rng_bad(mp_q, sum_q[63]);
					p1_q <= sum_q[63] ? (64'd0 - mp_q[63:0]) : mp_q[63:0];
					ma_q <= cdg_q; mp_q <= {64'd0, nmag};
					mcnt_q <= 6'd32; mbusy_q <= 1'b1;
				end
				OP_COMMIT: begin
					if (ovf_q || rng_bad(mp_q, num_q[31]) ||
						(add_s[64] != add_s[63])) begin
						err_q <= ERR_OVF;
					end else begin
						sum_q <= add_s[63:0];
						cd_q  <= ncd_q;
					end
				end
				OP_FDIV: begin
					sneg_q <= sum_q[63];
					dn_q <= smag; dd_q <= cd_q; dr_q <= '0; dq_q <= '0;
					dcnt_q <= 7'd64; dbusy_q <= 1'b1;
				end
				OP_FGCD: begin
					quo_q <= dq_q; rem_q <= dr_q;
					ga_q <= dr_q; gb_q <= cd_q; gk_q <= '0; gbusy_q <= 1'b1;
				end
				OP_FDEN: begin
					dn_q <= cd_q; dd_q <= g_q; dr_q <= '0; dq_q <= '0;
					dcnt_q <= 7'd64; dbusy_q <= 1'b1;
				end
				OP_FREM: begin
					fden_q <= dq_q[62:0];
					dn_q <= rem_q; dd_q <= g_q; dr_q <= '0; dq_q <= '0;
					dcnt_q <= 7'd64; dbusy_q <= 1'b1;
				end
				OP_CLEAR: begin
					if (err_q == ERR_NONE) begin
						res_int_q  <= sneg_q ? (64'd0 - quo_q) : quo_q;
						res_rem_q  <= sneg_q ? (64'd0 - dq_q) : dq_q;
						res_den_q  <= fden_q;
						res_form_q <= form_t'({quo_q != 64'd0, rem_q != 64'd0});
					end else begin
						res_int_q <= '0; res_rem_q <= '0; res_den_q <= 63'd1;
						res_form_q <= FORM_ZERO;
					end
					res_err_q <= err_q;
					sum_q <= '0; cd_q <= 64'd1; err_q <= ERR_NONE;
				end
				default: begin
				end
			endcase
		end
	end

	assign sts.busy     = dbusy_q | mbusy_q | gbusy_q;
	assign sts.err_held = (err_q != ERR_NONE);
	assign sts.last     = last_q;

	assign res_int  = res_int_q;
	assign res_rem  = res_rem_q;
	assign res_den  = res_den_q;
	assign res_form = res_form_q;
	assign res_err  = res_err_q;

endmodule

// ----- hw/rtl/rsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// rsa_ctrl
// Sequencer for fold and final mixed-number conversion.
// ----------------------------------------------------------------------------
module rsa_ctrl import rsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic in_last,
	input  logic in_den_zero,
	input  logic out_fire,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_ready,
	output logic out_valid
);

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_GCD  = 12'b000000000010,
		S_DCD  = 12'b000000000100,
		S_DDEN = 12'b000000001000,
		S_M1   = 12'b000000010000,
		S_M2   = 12'b000000100000,
		S_M3   = 12'b000001000000,
		S_FIN  = 12'b000010000000,
		S_FDIV = 12'b000100000000,
		S_FGCD = 12'b001000000000,
		S_FDEN = 12'b010000000000,
		S_FREM = 12'b100000000000
	} state_t;

	state_t st_q;
	logic   ovalid_q;
	logic   out_free;

	assign out_free = !ovalid_q || out_fire;

	always_comb begin
		cmd.op = OP_NONE;
		unique case (st_q)
			S_IDLE: if (in_fire) cmd.op = OP_LOAD;
			S_GCD:  if (!sts.busy) cmd.op = OP_DIVCD;
			S_DCD:  if (!sts.busy) cmd.op = OP_DIVDEN;
			S_DDEN: if (!sts.busy) cmd.op = OP_MUL1;
			S_M1:   if (!sts.busy) cmd.op = OP_MUL2;
			S_M2:   if (!sts.busy) cmd.op = OP_MUL3;
			S_M3:   if (!sts.busy) cmd.op = OP_COMMIT;
			S_FIN: begin
				if (!sts.err_held) cmd.op = OP_FDIV;
				else if (out_free) cmd.op = OP_CLEAR;
			end
			S_FDIV: if (!sts.busy) cmd.op = OP_FGCD;
			S_FGCD: if (!sts.busy) cmd.op = OP_FDEN;
			S_FDEN: if (!sts.busy) cmd.op = OP_FREM;
			S_FREM: if (!sts.busy && out_free) cmd.op = OP_CLEAR;
			default: cmd.op = OP_NONE;
		endcase
	end

	assign in_ready  = (st_q == S_IDLE);
	assign out_valid = ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; ovalid_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: if (in_fire) begin
					if (sts.err_held || in_den_zero)
						st_q <= in_last ? S_FIN : S_IDLE;
					else st_q <= S_GCD;
				end
				S_GCD:  if (!sts.busy) st_q <= S_DCD;
				S_DCD:  if (!sts.busy) st_q <= S_DDEN;
				S_DDEN: if (!sts.busy) st_q <= S_M1;
				S_M1:   if (!sts.busy) st_q <= S_M2;
				S_M2:   if (!sts.busy) st_q <= S_M3;
				S_M3:   if (!sts.busy) st_q <= sts.last ? S_FIN : S_IDLE;
				S_FIN: begin
					if (!sts.err_held) st_q <= S_FDIV;
					else if (out_free) st_q <= S_IDLE;
				end
				S_FDIV: if (!sts.busy) st_q <= S_FGCD;
				S_FGCD: if (!sts.busy) st_q <= S_FDEN;
				S_FDEN: if (!sts.busy) st_q <= S_FREM;
				S_FREM: if (!sts.busy && out_free) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
			if (cmd.op == OP_CLEAR) ovalid_q <= 1'b1;
			else if (out_fire) ovalid_q <= 1'b0;
		end
	end

endmodule
